[rtl/core/debug_module_dmi_registers_macros.svh]
// Assertion macros for the debug module register block.
// Used by debug_module_dmi_registers; expects clk and rst_n in scope.
`ifndef DEBUG_MODULE_DMI_REGISTERS_MACROS_SVH
`define DEBUG_MODULE_DMI_REGISTERS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dmr_pkg.sv]
// Types and constants for the debug module register block.
// No dependencies; imported by debug_module_dmi_registers.
package dmr_pkg;

    localparam logic [3:0] DATA_COUNT   = 4'd1;
    localparam logic [4:0] PROGBUF_SIZE = 5'd0;

    typedef enum logic [6:0] {
        ADDR_DATA0    = 7'h04,
        ADDR_CONTROL  = 7'h10,
        ADDR_STATUS   = 7'h11,
        ADDR_HARTINFO = 7'h12,
        ADDR_ABSCS    = 7'h16,
        ADDR_COMMAND  = 7'h17,
        ADDR_ABSAUTO  = 7'h18,
        ADDR_AUTHDATA = 7'h30
    } dmr_addr_t;

    typedef enum logic [2:0] {
        CMDERR_NONE          = 3'd0,
        CMDERR_NOT_SUPPORTED = 3'd2
    } dmr_cmderr_t;

    localparam logic [7:0]  CMDTYPE_ACCESS_REG = 8'h00;

    localparam logic [15:0] REGNO_GPR_FIRST = 16'h1000;
    localparam logic [15:0] REGNO_FPR_FIRST = 16'h1020;
    localparam logic [15:0] REGNO_FPR_LAST  = 16'h103F;
    localparam logic [15:0] REGNO_CSR_LAST  = 16'h0FFF;
    localparam logic [15:0] REGNO_DCSR      = 16'h07B0;

    localparam logic [31:0] DCSR_VALUE      = 32'h4000_0003;
    localparam logic [31:0] UNKNOWN_VALUE   = 32'hDEAD_BEEF;
    localparam logic [11:0] DATA_ADDR       = 12'h380;

    // Result word, read_data in the lowest bits.
    typedef struct packed {
        logic [31:0] hart_write_value;
        logic [4:0]  hart_access_index;
        logic        hart_access_float;
        logic        hart_access_write;
        logic        hart_access_valid;
        logic        access_ok;
        logic [31:0] read_data;
    } dmr_result_t;

endpackage

[rtl/core/debug_module_dmi_registers.sv]
// Registered path: request register, then result register.
// Throughput: one transaction per cycle unless the output stalls; decode and state update
// sit between the two registers; the result register loads whenever it is empty or read.
// Reset: dmactive, resume-ack, have-reset set; other DM state, valids cleared; no clearing pass.
// Depends on dmr_pkg and debug_module_dmi_registers_macros.svh.
`include "debug_module_dmi_registers_macros.svh"

module debug_module_dmi_registers
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // address[6:0], write_data[38:7], hart_read_value[70:39]
    input  logic        s_tuser,   // action (0 read, 1 write)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // read_data[31:0], access_ok[32], hart_access_valid[33],
                                   // hart_access_write[34], hart_access_float[35],
                                   // hart_access_index[40:36], hart_write_value[72:41]
);
    import dmr_pkg::*;

    // request register
    logic        req_valid_reg;
    logic        req_action_reg;
    logic [6:0]  req_address_reg;
    logic [31:0] req_wdata_reg;
    logic [31:0] req_hrv_reg;

    // result register
    logic        out_valid_reg;
    dmr_result_t out_reg;
    dmr_result_t out_next;

    // debug module state
    logic [8:0]  ctrl_reg,     ctrl_next;
    logic [9:0]  hartsel_reg,  hartsel_next;
    logic        halted_reg,   halted_next;
    logic        resack_reg,   resack_next;
    logic        havereset_reg, havereset_next;
    logic [2:0]  cmderr_reg,   cmderr_next;
    logic [31:0] data0_reg,    data0_next;

    logic        advance;
    logic [15:0] regno;
    logic        regno_is_reg;
    logic        regno_is_fpr;

    assign advance  = req_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !req_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg};

    assign regno        = req_wdata_reg[15:0];
    assign regno_is_reg = (regno >= REGNO_GPR_FIRST) && (regno <= REGNO_FPR_LAST);
    assign regno_is_fpr = (regno >= REGNO_FPR_FIRST);

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        hartsel_next   = hartsel_reg;
        halted_next    = halted_reg;
        resack_next    = resack_reg;
        havereset_next = havereset_reg;
        cmderr_next    = cmderr_reg;
        data0_next     = data0_reg;
        out_next       = '0;
        out_next.access_ok = 1'b1;

        if (!req_action_reg)
        begin
            case (req_address_reg)
                ADDR_CONTROL:
                begin
                    out_next.read_data = {ctrl_reg[8], ctrl_reg[7], 1'b0, ctrl_reg[6],
                                          1'b0, ctrl_reg[5], 4'b0,
                                          hartsel_reg[9:4] | {5'b0, ctrl_reg[4]},
                                          6'b0, hartsel_reg[3:0], 2'b0, ctrl_reg[3:0]};
                end
                ADDR_STATUS:
                begin
                    out_next.read_data = {12'b0, {2{havereset_reg}}, {2{resack_reg}},
                                          4'b0, {2{!halted_reg}}, {2{halted_reg}},
                                          8'h82};
                end
                ADDR_HARTINFO:
                    out_next.read_data = {8'h0, 4'h1, 3'b0, 1'b1, DATA_COUNT, DATA_ADDR};
                ADDR_ABSCS:
                    out_next.read_data = {3'b0, PROGBUF_SIZE, 13'b0, cmderr_reg,
                                          4'b0, DATA_COUNT};
                ADDR_DATA0:
                    out_next.read_data = data0_reg;
                ADDR_COMMAND, ADDR_ABSAUTO, ADDR_AUTHDATA:
                    out_next.read_data = '0;
                default:
                    out_next.access_ok = 1'b0;
            endcase
        end
        else
        begin
            case (req_address_reg)
                ADDR_CONTROL:
                begin
                    if (!ctrl_reg[0] && req_wdata_reg[0])
                        cmderr_next = CMDERR_NONE;
                    ctrl_next = {req_wdata_reg[31], req_wdata_reg[30], req_wdata_reg[28],
                                 req_wdata_reg[26], req_wdata_reg[16], req_wdata_reg[3:0]};
                    hartsel_next = req_wdata_reg[15:6];
                    // halt, then resume, then ack reset
                    if (req_wdata_reg[31])
                    begin
                        halted_next = 1'b1;
                        resack_next = 1'b0;
                    end
                    if (req_wdata_reg[30])
                    begin
                        halted_next = 1'b0;
                        resack_next = 1'b1;
                    end
                    if (req_wdata_reg[28])
                        havereset_next = 1'b0;
                end
                ADDR_DATA0:
                    data0_next = req_wdata_reg;
                ADDR_AUTHDATA, ADDR_ABSAUTO:
                    out_next.access_ok = 1'b1;
                ADDR_ABSCS:
                begin
                    if (req_wdata_reg[10:8] != 3'b0)
                        cmderr_next = CMDERR_NONE;
                end
                ADDR_COMMAND:
                begin
                    if (req_wdata_reg[31:24] != CMDTYPE_ACCESS_REG)
                    begin
                        cmderr_next        = CMDERR_NOT_SUPPORTED;
                        out_next.access_ok = 1'b0;
                    end
                    else if (req_wdata_reg[17])
                    begin
                        if (req_wdata_reg[16])
                        begin
                            // x0 is hardwired, drop the write
                            if (regno_is_reg && !(!regno_is_fpr && regno[4:0] == 5'd0))
                            begin
                                out_next.hart_access_valid = 1'b1;
                                out_next.hart_access_write = 1'b1;
                                out_next.hart_access_float = regno_is_fpr;
                                out_next.hart_access_index = regno[4:0];
                                out_next.hart_write_value  = data0_reg;
                            end
                        end
                        else if (regno_is_reg)
                        begin
                            out_next.hart_access_valid = 1'b1;
                            out_next.hart_access_float = regno_is_fpr;
                            out_next.hart_access_index = regno[4:0];
                            data0_next = req_hrv_reg;
                        end
                        else if (regno == REGNO_DCSR)
                            data0_next = DCSR_VALUE;
                        else if (regno <= REGNO_CSR_LAST)
                            data0_next = '0;
                        else
                            data0_next = UNKNOWN_VALUE;
                    end
                end
                default:
                    out_next.access_ok = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= 9'h001;
            hartsel_reg   <= '0;
            halted_reg    <= 1'b0;
            resack_reg    <= 1'b1;
            havereset_reg <= 1'b1;
            cmderr_reg    <= CMDERR_NONE;
            data0_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                req_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ctrl_reg      <= ctrl_next;
                hartsel_reg   <= hartsel_next;
                halted_reg    <= halted_next;
                resack_reg    <= resack_next;
                havereset_reg <= havereset_next;
                cmderr_reg    <= cmderr_next;
                data0_reg     <= data0_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_action_reg  <= s_tuser;
            req_address_reg <= s_tdata[6:0];
            req_wdata_reg   <= s_tdata[38:7];
            req_hrv_reg     <= s_tdata[70:39];
        end
        if (advance)
            out_reg <= out_next;
    end

    `DMR_ASSERT_NOW(a_cmderr_codes, 1'b1,
        cmderr_reg == CMDERR_NONE || cmderr_reg == CMDERR_NOT_SUPPORTED,
        "command error holds an unexpected code")
    `DMR_ASSERT_NOW(a_halt_ack_excl, 1'b1, !(halted_reg && resack_reg),
        "hart halted while resume acknowledged")
    `DMR_ASSERT_NOW(a_hart_fields_idle, out_valid_reg && !out_reg.hart_access_valid,
        !out_reg.hart_access_write && !out_reg.hart_access_float &&
        out_reg.hart_access_index == 5'd0,
        "hart access fields set without a hart access")
    `DMR_ASSERT_NOW(a_hart_wval_idle, out_valid_reg && !out_reg.hart_access_write,
        out_reg.hart_write_value == 32'd0,
        "hart write value set without a hart write")
    `DMR_ASSERT_NEXT(a_req_held, req_valid_reg && !advance,
        req_valid_reg && $stable(req_address_reg) && $stable(req_wdata_reg),
        "stalled request changed before it advanced")

endmodule
